>>> sv/uuidg_pkg.sv
// ============================================================================
// uuidg_pkg
// Shared types, constants and microprogram for the UUID v4 generator.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package uuidg_pkg;

    localparam int unsigned StateW = 64;
    localparam int unsigned CountW = 7;
    localparam int unsigned StepW  = 4;
    localparam int unsigned ByteW  = 4;

    localparam logic [StateW-1:0] GoldenGamma = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [StateW-1:0] MixMulA     = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [StateW-1:0] MixMulB     = 64'h94D0_49BB_1331_11EB;

    localparam logic [ByteW-1:0] VersionByte = 4'd7;
    localparam logic [ByteW-1:0] VariantByte = 4'd8;
    localparam logic [ByteW-1:0] LastByte    = 4'd15;

    localparam logic [StepW-1:0] StepIdle = 4'd0;
    localparam logic [StepW-1:0] StepAdv  = 4'd1;
    localparam logic [StepW-1:0] StepEmit = 4'd10;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_ADV,
        OP_MUL,
        OP_MIX,
        OP_BYTE,
        OP_EMIT
    } uuidg_op_t;

    typedef enum logic [1:0] {
        MP_LL,
        MP_LH,
        MP_HL
    } uuidg_mpart_t;

    typedef enum logic {
        KSEL_A,
        KSEL_B
    } uuidg_ksel_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_WAIT_IN,
        JMP_BYTE,
        JMP_EMIT
    } uuidg_jmp_t;

    typedef struct packed {
        uuidg_op_t    op;
        uuidg_mpart_t mpart;
        uuidg_ksel_t  ksel;
        uuidg_jmp_t   jmp;
    } uuidg_cw_t;

    typedef struct packed {
        uuidg_op_t        op;
        uuidg_mpart_t     mpart;
        uuidg_ksel_t      ksel;
        logic [ByteW-1:0] byte_idx;
        logic             seed_load;
        logic             out_load;
        logic             out_bad;
    } uuidg_ctl_t;

    // Microprogram: one state advance, two 64-bit mixes on a shared
    // 32x32 multiplier, byte extract, then loop or emit.
    function automatic uuidg_cw_t prog_word(input logic [StepW-1:0] pc);
        uuidg_cw_t cw;
        cw = '{op: OP_IDLE, mpart: MP_LL, ksel: KSEL_A, jmp: JMP_WAIT_IN};
        case (pc)
            4'd0:    cw = '{op: OP_IDLE, mpart: MP_LL, ksel: KSEL_A, jmp: JMP_WAIT_IN};
            4'd1:    cw = '{op: OP_ADV,  mpart: MP_LL, ksel: KSEL_A, jmp: JMP_NEXT};
            4'd2:    cw = '{op: OP_MUL,  mpart: MP_LL, ksel: KSEL_A, jmp: JMP_NEXT};
            4'd3:    cw = '{op: OP_MUL,  mpart: MP_LH, ksel: KSEL_A, jmp: JMP_NEXT};
            4'd4:    cw = '{op: OP_MUL,  mpart: MP_HL, ksel: KSEL_A, jmp: JMP_NEXT};
            4'd5:    cw = '{op: OP_MIX,  mpart: MP_LL, ksel: KSEL_A, jmp: JMP_NEXT};
            4'd6:    cw = '{op: OP_MUL,  mpart: MP_LL, ksel: KSEL_B, jmp: JMP_NEXT};
            4'd7:    cw = '{op: OP_MUL,  mpart: MP_LH, ksel: KSEL_B, jmp: JMP_NEXT};
            4'd8:    cw = '{op: OP_MUL,  mpart: MP_HL, ksel: KSEL_B, jmp: JMP_NEXT};
            4'd9:    cw = '{op: OP_BYTE, mpart: MP_LL, ksel: KSEL_A, jmp: JMP_BYTE};
            4'd10:   cw = '{op: OP_EMIT, mpart: MP_LL, ksel: KSEL_A, jmp: JMP_EMIT};
            default: cw = '{op: OP_IDLE, mpart: MP_LL, ksel: KSEL_A, jmp: JMP_WAIT_IN};
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

>>> sv/uuidg_if.sv
// ============================================================================
// uuidg_req_if / uuidg_rsp_if
// Valid/ready channels for generator requests and UUID results.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface uuidg_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [63:0] seed_value;
    logic [6:0]  uuid_count;

    modport source (output valid, output action, output seed_value, output uuid_count,
                    input ready);
    modport sink   (input valid, input action, input seed_value, input uuid_count,
                    output ready);
endinterface

interface uuidg_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] uuid_bytes_low;
    logic [63:0] uuid_bytes_high;
    logic        last_uuid;
    logic        bad_count;

    modport source (output valid, output uuid_bytes_low, output uuid_bytes_high,
                    output last_uuid, output bad_count, input ready);
    modport sink   (input valid, input uuid_bytes_low, input uuid_bytes_high,
                    input last_uuid, input bad_count, output ready);
endinterface

`default_nettype wire

>>> sv/uuidg_seq.sv
// ============================================================================
// uuidg_seq
// Microcode sequencer: step counter, program ROM, byte and UUID counters.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module uuidg_seq #(
    parameter int unsigned MAX_UUIDS = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    input  wire logic                          req_action,
    input  wire logic [uuidg_pkg::CountW-1:0]  req_count,
    output logic                               req_ready,
    input  wire logic                          rsp_ready,
    output logic                               rsp_valid,
    output uuidg_pkg::uuidg_ctl_t              ctl,
    output logic                               last_out
);

    logic [uuidg_pkg::StepW-1:0]  pc_reg, pc_next;
    logic [uuidg_pkg::ByteW-1:0]  byte_reg, byte_next;
    logic [uuidg_pkg::CountW-1:0] rem_reg, rem_next;
    logic                         bad_reg, bad_next;
    logic                         valid_reg, valid_next;

    uuidg_pkg::uuidg_cw_t cw;
    logic accept, out_free, emit, last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= uuidg_pkg::StepIdle;
            byte_reg  <= '0;
            rem_reg   <= '0;
            bad_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg    <= pc_next;
            byte_reg  <= byte_next;
            rem_reg   <= rem_next;
            bad_reg   <= bad_next;
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        cw        = uuidg_pkg::prog_word(pc_reg);
        req_ready = (cw.jmp == uuidg_pkg::JMP_WAIT_IN);
        accept    = req_valid && req_ready;
        out_free  = !valid_reg || rsp_ready;
        emit      = (cw.op == uuidg_pkg::OP_EMIT) && out_free;
        last      = bad_reg || (rem_reg == uuidg_pkg::CountW'(1));

        pc_next    = pc_reg;
        byte_next  = byte_reg;
        rem_next   = rem_reg;
        bad_next   = bad_reg;
        valid_next = valid_reg;

        if (rsp_ready)
            valid_next = 1'b0;
        if (emit)
            valid_next = 1'b1;

        if (cw.op == uuidg_pkg::OP_BYTE)
            byte_next = byte_reg + uuidg_pkg::ByteW'(1);

        if (accept && req_action)
        begin
            byte_next = '0;
            if (req_count == '0)
            begin
                bad_next = 1'b1;
                rem_next = '0;
            end
            else if (req_count > uuidg_pkg::CountW'(MAX_UUIDS))
                rem_next = uuidg_pkg::CountW'(MAX_UUIDS);
            else
                rem_next = req_count;
        end

        if (emit)
        begin
            bad_next = 1'b0;
            if (!bad_reg)
                rem_next = rem_reg - uuidg_pkg::CountW'(1);
        end

        case (cw.jmp)
            uuidg_pkg::JMP_NEXT:
                pc_next = pc_reg + uuidg_pkg::StepW'(1);
            uuidg_pkg::JMP_WAIT_IN:
                if (accept && req_action)
                    pc_next = (req_count == '0) ? uuidg_pkg::StepEmit : uuidg_pkg::StepAdv;
            uuidg_pkg::JMP_BYTE:
                pc_next = (byte_reg == uuidg_pkg::LastByte) ? uuidg_pkg::StepEmit
                                                            : uuidg_pkg::StepAdv;
            uuidg_pkg::JMP_EMIT:
                if (out_free)
                    pc_next = last ? uuidg_pkg::StepIdle : uuidg_pkg::StepAdv;
            default:
                pc_next = uuidg_pkg::StepIdle;
        endcase

        ctl.op        = cw.op;
        ctl.mpart     = cw.mpart;
        ctl.ksel      = cw.ksel;
        ctl.byte_idx  = byte_reg;
        ctl.seed_load = accept && !req_action;
        ctl.out_load  = emit;
        ctl.out_bad   = bad_reg;
    end

    assign rsp_valid = valid_reg;
    assign last_out  = last;

endmodule

`default_nettype wire

>>> sv/uuidg_dp.sv
// ============================================================================
// uuidg_dp
// Datapath: generator state, shared 32x32 multiplier, UUID assembly, output.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module uuidg_dp (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire uuidg_pkg::uuidg_ctl_t        ctl,
    input  wire logic [uuidg_pkg::StateW-1:0] seed_value,
    output logic [63:0]                       uuid_bytes_low,
    output logic [63:0]                       uuid_bytes_high,
    output logic                              last_uuid,
    input  wire logic                         last_in,
    output logic                              bad_count
);

    logic [uuidg_pkg::StateW-1:0] state_reg, state_next;
    logic [63:0]  x_reg, x_next;
    logic [63:0]  acc_reg, acc_next;
    logic [127:0] uuid_reg, uuid_next;
    logic [63:0]  lo_reg, lo_next, hi_reg, hi_next;
    logic         last_reg, last_next, bad_reg, bad_next;

    logic [63:0] kconst;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [63:0] adv;
    logic [7:0]  rnd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= 64'd1;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        acc_reg  <= acc_next;
        uuid_reg <= uuid_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        last_reg <= last_next;
        bad_reg  <= bad_next;
    end

    always_comb
    begin
        kconst = (ctl.ksel == uuidg_pkg::KSEL_B) ? uuidg_pkg::MixMulB : uuidg_pkg::MixMulA;
        case (ctl.mpart)
            uuidg_pkg::MP_LL:
            begin
                mul_a = x_reg[31:0];
                mul_b = kconst[31:0];
            end
            uuidg_pkg::MP_LH:
            begin
                mul_a = x_reg[31:0];
                mul_b = kconst[63:32];
            end
            uuidg_pkg::MP_HL:
            begin
                mul_a = x_reg[63:32];
                mul_b = kconst[31:0];
            end
            default:
            begin
                mul_a = x_reg[31:0];
                mul_b = kconst[31:0];
            end
        endcase
        prod = 64'(mul_a) * 64'(mul_b);
        adv  = state_reg + uuidg_pkg::GoldenGamma;
        rnd  = acc_reg[7:0] ^ acc_reg[38:31];
        if (ctl.byte_idx == uuidg_pkg::VersionByte)
            rnd = {4'b0100, rnd[3:0]};
        else if (ctl.byte_idx == uuidg_pkg::VariantByte)
            rnd = {2'b10, rnd[5:0]};

        state_next = state_reg;
        x_next     = x_reg;
        acc_next   = acc_reg;
        uuid_next  = uuid_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        last_next  = last_reg;
        bad_next   = bad_reg;

        if (ctl.seed_load)
            state_next = (seed_value == '0) ? 64'd1 : seed_value;

        case (ctl.op)
            uuidg_pkg::OP_ADV:
            begin
                state_next = adv;
                x_next     = adv ^ (adv >> 30);
            end
            uuidg_pkg::OP_MUL:
                if (ctl.mpart == uuidg_pkg::MP_LL)
                    acc_next = prod;
                else
                    acc_next[63:32] = acc_reg[63:32] + prod[31:0];
            uuidg_pkg::OP_MIX:
                x_next = acc_reg ^ (acc_reg >> 27);
            uuidg_pkg::OP_BYTE:
                uuid_next = {rnd, uuid_reg[127:8]};
            default:
                ;
        endcase

        if (ctl.out_load)
        begin
            lo_next   = ctl.out_bad ? 64'd0 : uuid_reg[63:0];
            hi_next   = ctl.out_bad ? 64'd0 : uuid_reg[127:64];
            last_next = last_in;
            bad_next  = ctl.out_bad;
        end
    end

    assign uuid_bytes_low  = lo_reg;
    assign uuid_bytes_high = hi_reg;
    assign last_uuid       = last_reg;
    assign bad_count       = bad_reg;

endmodule

`default_nettype wire

>>> sv/uuid_v4_generator.sv
// ============================================================================
// uuid_v4_generator
// Version-4 UUID generator on a splitmix64 byte source, microcoded control.
// ============================================================================
//  channel | dir | payload                                          | meaning
//  req     | in  | action, seed_value, uuid_count                   | reseed/generate
//  rsp     | out | uuid_bytes_low, uuid_bytes_high, last_uuid, bad | one UUID
//
//  Each random byte runs advance, 2 x 3 passes on one 32x32 multiplier,
//  xor-shift and extract; a UUID is 16 bytes followed by an emit step.
//  Reseed is taken in the idle step; a zero count jumps to emit for its error result.
//  Reset loads generator state 1 and returns the sequencer to idle.
//  A waiting result stalls the sequencer only at its emit step.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module uuid_v4_generator #(
    parameter int unsigned MAX_UUIDS = 64
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    uuidg_req_if.sink   req,
    uuidg_rsp_if.source rsp
);

    uuidg_pkg::uuidg_ctl_t ctl;
    logic                  last_pending;

    uuidg_seq #(
        .MAX_UUIDS (MAX_UUIDS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_action (req.action),
        .req_count  (req.uuid_count),
        .req_ready  (req.ready),
        .rsp_ready  (rsp.ready),
        .rsp_valid  (rsp.valid),
        .ctl        (ctl),
        .last_out   (last_pending)
    );

    uuidg_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .seed_value      (req.seed_value),
        .uuid_bytes_low  (rsp.uuid_bytes_low),
        .uuid_bytes_high (rsp.uuid_bytes_high),
        .last_uuid       (rsp.last_uuid),
        .last_in         (last_pending),
        .bad_count       (rsp.bad_count)
    );

endmodule

`default_nettype wire

>>> dv/tb_uuid_v4_generator.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_uuid_v4_generator
// Drives reseed and generate requests through the request channel, predicts
// every UUID from a splitmix64 byte stream kept in the bench, and compares
// each response field by field under random source and sink idling.
// ============================================================================

module tb_uuid_v4_generator;

    localparam int unsigned MaxUuids   = 64;
    localparam int unsigned CycleLimit = 20_000_000;
    localparam int unsigned HoldCycles = 1500;
    localparam int unsigned TailCycles = 200;

    localparam logic ACT_RESEED   = 1'b0;
    localparam logic ACT_GENERATE = 1'b1;

    typedef struct packed {
        logic [63:0] uuid_lo;
        logic [63:0] uuid_hi;
        logic        last;
        logic        bad;
    } uuid_rsp_t;

    logic clk;
    logic rst_n;

    uuidg_req_if req_ch();
    uuidg_rsp_if rsp_ch();

    uuid_v4_generator #(
        .MAX_UUIDS(MaxUuids)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    logic [63:0] gen_state = 64'd1;
    uuid_rsp_t   pending_uuids[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    logic        rsp_stalled    = 1'b0;
    event        rsp_hold_ev;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("FAIL uuid_v4_generator");
            $finish;
        end
    end

    // Long sink hold-off, counted here so the request side keeps running.
    always
    begin
        @(rsp_hold_ev);
        rsp_stalled <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        rsp_stalled <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rsp_stalled)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic logic [7:0] splitmix_byte();
        logic [63:0] z;
        gen_state = gen_state + uuidg_pkg::GoldenGamma;
        z = gen_state;
        z = (z ^ (z >> 30)) * uuidg_pkg::MixMulA;
        z = (z ^ (z >> 27)) * uuidg_pkg::MixMulB;
        z = z ^ (z >> 31);
        return z[7:0];
    endfunction

    function automatic void predict_request(input logic act, input logic [63:0] seed,
                                            input logic [6:0] cnt);
        int unsigned  n;
        logic [127:0] uuid_word;
        logic [7:0]   byt;
        uuid_rsp_t    r;
        if (act == ACT_RESEED)
        begin
            gen_state = (seed == 64'd0) ? 64'd1 : seed;
            return;
        end
        if (cnt == 7'd0)
        begin
            r = '{uuid_lo: 64'd0, uuid_hi: 64'd0, last: 1'b1, bad: 1'b1};
            pending_uuids.push_back(r);
            return;
        end
        n = (cnt > MaxUuids) ? MaxUuids : cnt;
        for (int u = 0; u < n; u++)
        begin
            uuid_word = '0;
            for (int pos = 0; pos < 16; pos++)
            begin
                byt = splitmix_byte();
                if (pos[uuidg_pkg::ByteW-1:0] == uuidg_pkg::VersionByte)
                    byt = {4'b0100, byt[3:0]};
                else if (pos[uuidg_pkg::ByteW-1:0] == uuidg_pkg::VariantByte)
                    byt = {2'b10, byt[5:0]};
                uuid_word[pos*8 +: 8] = byt;
            end
            r.uuid_lo = uuid_word[63:0];
            r.uuid_hi = uuid_word[127:64];
            r.last    = (u == n - 1);
            r.bad     = 1'b0;
            pending_uuids.push_back(r);
        end
    endfunction

    // Valid stays high across back-to-back requests; it drops only on an idle gap.
    task automatic send_request(input logic act, input logic [63:0] seed,
                                input logic [6:0] cnt);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        req_ch.valid      <= 1'b1;
        req_ch.action     <= act;
        req_ch.seed_value <= seed;
        req_ch.uuid_count <= cnt;
        do @(posedge clk); while (!req_ch.ready);
        predict_request(act, seed, cnt);
    endtask

    always @(posedge clk)
    begin
        uuid_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_uuids.size() == 0)
            begin
                $error("unexpected result: low %h high %h last %b bad %b",
                       rsp_ch.uuid_bytes_low, rsp_ch.uuid_bytes_high,
                       rsp_ch.last_uuid, rsp_ch.bad_count);
                mismatch_count++;
            end
            else
            begin
                want = pending_uuids.pop_front();
                if (rsp_ch.uuid_bytes_low !== want.uuid_lo)
                begin
                    $error("uuid_bytes_low: expected %h, got %h",
                           want.uuid_lo, rsp_ch.uuid_bytes_low);
                    mismatch_count++;
                end
                if (rsp_ch.uuid_bytes_high !== want.uuid_hi)
                begin
                    $error("uuid_bytes_high: expected %h, got %h",
                           want.uuid_hi, rsp_ch.uuid_bytes_high);
                    mismatch_count++;
                end
                if (rsp_ch.last_uuid !== want.last)
                begin
                    $error("last_uuid: expected %b, got %b", want.last, rsp_ch.last_uuid);
                    mismatch_count++;
                end
                if (rsp_ch.bad_count !== want.bad)
                begin
                    $error("bad_count: expected %b, got %b", want.bad, rsp_ch.bad_count);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic logic [63:0] pick_seed();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            return 64'd0;
        else if (sel < 15)
            return '1;
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [6:0] pick_count();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 6)
            return 7'd0;
        else if (sel < 8)
            return 7'(MaxUuids);
        else if (sel < 11)
            return 7'($urandom_range(MaxUuids + 1, 127));
        return 7'($urandom_range(1, 4));
    endfunction

    task automatic test_reset_state();
        send_request(ACT_GENERATE, '1, 7'd1);
        send_request(ACT_GENERATE, 64'd0, 7'd2);
    endtask

    task automatic test_reseed();
        send_request(ACT_RESEED, 64'h0123_4567_89AB_CDEF, 7'd0);
        send_request(ACT_GENERATE, 64'd0, 7'd1);
        send_request(ACT_RESEED, 64'd0, 7'd127);
        send_request(ACT_GENERATE, 64'h5555_5555_5555_5555, 7'd1);
        send_request(ACT_RESEED, '1, 7'd64);
        send_request(ACT_GENERATE, 64'hAAAA_AAAA_AAAA_AAAA, 7'd3);
        send_request(ACT_RESEED, 64'h8000_0000_0000_0000, 7'd1);
        send_request(ACT_GENERATE, '1, 7'd1);
    endtask

    task automatic test_count_limits();
        send_request(ACT_GENERATE, {$urandom(), $urandom()}, 7'd0);
        send_request(ACT_GENERATE, 64'd0, 7'(MaxUuids));
        send_request(ACT_GENERATE, '1, 7'(MaxUuids + 1));
        send_request(ACT_RESEED, 64'd1, 7'd0);
        send_request(ACT_GENERATE, 64'd0, 7'd127);
        send_request(ACT_GENERATE, 64'd0, 7'd0);
    endtask

    task automatic test_random_traffic(input int unsigned n_items, input int unsigned s_pct,
                                       input int unsigned r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 99) < 30)
                send_request(ACT_RESEED, pick_seed(), 7'($urandom_range(0, 127)));
            else
                send_request(ACT_GENERATE, pick_seed(), pick_count());
        end
    endtask

    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        -> rsp_hold_ev;
        for (int i = 0; i < 6; i++)
            send_request(ACT_GENERATE, {$urandom(), $urandom()}, 7'd2);
        send_request(ACT_RESEED, {$urandom(), $urandom()}, 7'd5);
        send_request(ACT_GENERATE, 64'd0, 7'd0);
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.action     <= ACT_RESEED;
        req_ch.seed_value <= 64'd0;
        req_ch.uuid_count <= 7'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 23;
        recv_idle_pct = 83;
        test_reset_state();
        test_reseed();
        test_count_limits();
        test_random_traffic(78, 23, 83);
        test_random_traffic(78, 83, 23);
        test_random_traffic(78, 0, 0);
        test_output_stall();

        req_ch.valid <= 1'b0;
        while (pending_uuids.size() != 0) @(posedge clk);
        repeat (TailCycles) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS uuid_v4_generator");
        else
            $display("FAIL uuid_v4_generator");
        $finish;
    end

endmodule
